// ===== hdl/axis_angle_rotation_matrix_macros.svh =====
// Assertion helpers shared by the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AARM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define AARM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/aarm_pkg.sv =====
// ------------------------------------------------------------------------
// aarm_pkg
// Types and constants of the axis-angle rotation matrix pipeline.
// ------------------------------------------------------------------------
package aarm_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [16:0] Q13_PI      = 17'sd25736;
    localparam logic signed [16:0] Q13_HALF_PI = 17'sd12868;
    localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
    } t_out;

    // CORDIC result handed to the matrix stages
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic               flip;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_rot;

    // Arctangent of 2^-i in Q30
    function automatic logic signed [32:0] atan_q30(input int idx);
        logic signed [32:0] v;
        case (idx)
            0:       v = 33'sd843314857;
            1:       v = 33'sd497837829;
            2:       v = 33'sd263043837;
            3:       v = 33'sd133525159;
            4:       v = 33'sd67021687;
            5:       v = 33'sd33543516;
            6:       v = 33'sd16775851;
            7:       v = 33'sd8388438;
            8:       v = 33'sd4194283;
            9:       v = 33'sd2097150;
            10:      v = 33'sd1048576;
            11:      v = 33'sd524288;
            12:      v = 33'sd262144;
            13:      v = 33'sd131072;
            14:      v = 33'sd65536;
            15:      v = 33'sd32768;
            16:      v = 33'sd16384;
            17:      v = 33'sd8192;
            18:      v = 33'sd4096;
            19:      v = 33'sd2048;
            20:      v = 33'sd1024;
            21:      v = 33'sd512;
            22:      v = 33'sd256;
            23:      v = 33'sd128;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/aarm_cordic.sv =====
// ------------------------------------------------------------------------
// aarm_cordic
// Quadrant fold plus one register stage per CORDIC rotation.
// ------------------------------------------------------------------------
module aarm_cordic
    import aarm_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_valid,
    output t_rot o_rot
);

    logic signed [32:0] r_x [0:STAGES];
    logic signed [32:0] r_y [0:STAGES];
    logic signed [32:0] r_z [0:STAGES];
    t_rot               r_meta [0:STAGES];
    logic [STAGES:0]    r_vld;

    logic signed [16:0] w_ang;
    logic signed [16:0] w_fold;
    logic signed [32:0] w_fold_ext;
    logic               w_flip;

    // Fold the angle into plus or minus pi/2
    always_comb begin
        w_ang  = 17'(i_data.angle);
        w_fold = w_ang;
        w_flip = 1'b0;
        if (w_ang > Q13_HALF_PI) begin
            w_fold = w_ang - Q13_PI;
            w_flip = 1'b1;
        end else if (w_ang < -Q13_HALF_PI) begin
            w_fold = w_ang + Q13_PI;
            w_flip = 1'b1;
        end
        w_fold_ext = 33'(w_fold);
    end

    // Load the first stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]           <= GAIN_Q30;
            r_y[0]           <= '0;
            r_z[0]           <= w_fold_ext <<< 17;
            r_meta[0].x      <= '0;
            r_meta[0].y      <= '0;
            r_meta[0].flip   <= w_flip;
            r_meta[0].axis_x <= i_data.axis_x;
            r_meta[0].axis_y <= i_data.axis_y;
            r_meta[0].axis_z <= i_data.axis_z;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    // Rotate once per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
                r_meta[g+1] <= r_meta[g];
            end
        end
    end

    always_comb begin
        o_rot   = r_meta[STAGES];
        o_rot.x = r_x[STAGES];
        o_rot.y = r_y[STAGES];
    end
    assign o_valid = r_vld[STAGES];

endmodule

// ===== hdl/aarm_matrix.sv =====
// ------------------------------------------------------------------------
// aarm_matrix
// Rounds cos and sin, forms products and the nine saturated entries.
// ------------------------------------------------------------------------
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_rot i_rot,
    output logic o_valid,
    output t_out o_data
);

    logic [4:0] r_vld;

    // Round stage
    logic signed [32:0] w_xn, w_yn, w_xr, w_yr;
    logic signed [16:0] r_c, r_s;
    logic signed [17:0] r_t;
    logic signed [15:0] r_ax, r_ay, r_az;

    // Product stage
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [32:0] r_xs, r_ys, r_zs;
    logic signed [16:0] r_c2;
    logic signed [17:0] r_t2;

    // Scale stage
    logic signed [49:0] r_xxt, r_yyt, r_zzt, r_xyt, r_xzt, r_yzt;
    logic signed [46:0] r_xs3, r_ys3, r_zs3;
    logic signed [44:0] r_cq;

    // Sum stage
    logic signed [51:0] r_e [0:8];
    logic signed [51:0] w_xs, w_ys, w_zs, w_cq;

    // Output stage
    t_out r_out;

    function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
        logic signed [23:0] q;
        logic signed [15:0] r;
        q = v[51:28];
        if (q > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    // Undo the fold and round to Q14
    always_comb begin
        w_xn = i_rot.flip ? -i_rot.x : i_rot.x;
        w_yn = i_rot.flip ? -i_rot.y : i_rot.y;
        w_xr = w_xn + 33'sd32768;
        w_yr = w_yn + 33'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= w_xr[32:16];
            r_s  <= w_yr[32:16];
            r_t  <= ONE_Q14 - 18'($signed(w_xr[32:16]));
            r_ax <= i_rot.axis_x;
            r_ay <= i_rot.axis_y;
            r_az <= i_rot.axis_z;
        end
    end

    // Multiply axis pairs and axis by sine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= r_ax * r_ax;
            r_yy <= r_ay * r_ay;
            r_zz <= r_az * r_az;
            r_xy <= r_ax * r_ay;
            r_xz <= r_ax * r_az;
            r_yz <= r_ay * r_az;
            r_xs <= r_ax * r_s;
            r_ys <= r_ay * r_s;
            r_zs <= r_az * r_s;
            r_c2 <= r_c;
            r_t2 <= r_t;
        end
    end

    // Scale by t and align to Q42
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xxt <= r_xx * r_t2;
            r_yyt <= r_yy * r_t2;
            r_zzt <= r_zz * r_t2;
            r_xyt <= r_xy * r_t2;
            r_xzt <= r_xz * r_t2;
            r_yzt <= r_yz * r_t2;
            r_xs3 <= 47'(r_xs) <<< 14;
            r_ys3 <= 47'(r_ys) <<< 14;
            r_zs3 <= 47'(r_zs) <<< 14;
            r_cq  <= 45'(r_c2) <<< 28;
        end
    end

    // Sum each entry with the rounding offset
    always_comb begin
        w_xs = 52'(r_xs3);
        w_ys = 52'(r_ys3);
        w_zs = 52'(r_zs3);
        w_cq = 52'(r_cq) + (52'sd1 <<< 27);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= w_cq + 52'(r_xxt);
            r_e[1] <= 52'(r_xyt) - w_zs + (52'sd1 <<< 27);
            r_e[2] <= 52'(r_xzt) + w_ys + (52'sd1 <<< 27);
            r_e[3] <= 52'(r_xyt) + w_zs + (52'sd1 <<< 27);
            r_e[4] <= w_cq + 52'(r_yyt);
            r_e[5] <= 52'(r_yzt) - w_xs + (52'sd1 <<< 27);
            r_e[6] <= 52'(r_xzt) - w_ys + (52'sd1 <<< 27);
            r_e[7] <= 52'(r_yzt) + w_xs + (52'sd1 <<< 27);
            r_e[8] <= w_cq + 52'(r_zzt);
        end
    end

    // Saturate into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.rot_00 <= sat16(r_e[0]);
            r_out.rot_01 <= sat16(r_e[1]);
            r_out.rot_02 <= sat16(r_e[2]);
            r_out.rot_10 <= sat16(r_e[3]);
            r_out.rot_11 <= sat16(r_e[4]);
            r_out.rot_12 <= sat16(r_e[5]);
            r_out.rot_20 <= sat16(r_e[6]);
            r_out.rot_21 <= sat16(r_e[7]);
            r_out.rot_22 <= sat16(r_e[8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_data  = r_out;

endmodule

// ===== hdl/axis_angle_rotation_matrix.sv =====
// Pipeline: CORDIC load and rotation registers, then round, product, scale, sum and output.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken, set by the single output register.
// Reset: synchronous active-low i_rst_n clears all valid bits; data is not reset.
// ------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis-angle to 3x3 rotation matrix: pipelined CORDIC, then product stages.
// ------------------------------------------------------------------------
`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix
    import aarm_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic w_en;
    logic w_rot_vld;
    t_rot w_rot;

    // Advance every stage while the output register can move
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    aarm_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_rot_vld),
        .o_rot   (w_rot)
    );

    aarm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_vld),
        .i_rot   (w_rot),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    `AARM_ASSERT_IMP(a_empty_takes, !o_out_valid, o_in_ready)
    `AARM_ASSERT_NXT(a_stall_holds_vld, !w_en, $stable(w_rot_vld))
    `AARM_ASSERT_NXT(a_stall_holds_rot, !w_en, $stable(w_rot))

endmodule

// ===== verif/axis_angle_rotation_matrix_test.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// axis_angle_rotation_matrix_test
// Streams angle/axis beats through the rotation matrix pipeline, predicts
// each 3x3 matrix with a bit-exact CORDIC and Rodrigues model, and compares
// every output beat as a whole, under random idling on both sides but in streaming.
// ------------------------------------------------------------------------
module axis_angle_rotation_matrix_test;
    import aarm_pkg::*;

    localparam int STAGES  = 16;
    localparam int LATENCY = STAGES + 6;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    t_out matrix_q[$];
    int   mismatches;
    bit   quiet;
    int   out_idle;

    axis_angle_rotation_matrix #(.CORDIC_STAGES(STAGES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // floor shift of a signed 64-bit value
    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    // Round Q42 to Q14 half up and saturate
    function automatic logic signed [15:0] round_sat(longint q42);
        longint r;
        r = fshr(q42 + (64'sd1 <<< 27), 28);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_out rotation_matrix(t_in a);
        longint ang, ax, ay, az, x, y, z, dx, dy, c, s, t, cq, xs, ys, zs, xy, xz, yz;
        bit     flip;
        t_out   m;
        ang = a.angle; ax = a.axis_x; ay = a.axis_y; az = a.axis_z;
        flip = 0;
        if (ang > Q13_HALF_PI) begin
            ang -= Q13_PI; flip = 1;
        end else if (ang < -Q13_HALF_PI) begin
            ang += Q13_PI; flip = 1;
        end
        z = ang * 131072;
        x = GAIN_Q30;
        y = 0;
        // rotate toward zero residual angle
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q30(i);
            end else begin
                x += dx; y -= dy; z += atan_q30(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = fshr(x + 32768, 16);
        s = fshr(y + 32768, 16);
        t = 16384 - c;
        cq = c * (64'sd1 <<< 28);
        xs = ax * s * 16384; ys = ay * s * 16384; zs = az * s * 16384;
        xy = ax * ay * t; xz = ax * az * t; yz = ay * az * t;
        m.rot_00 = round_sat(cq + ax * ax * t);
        m.rot_01 = round_sat(xy - zs);
        m.rot_02 = round_sat(xz + ys);
        m.rot_10 = round_sat(xy + zs);
        m.rot_11 = round_sat(cq + ay * ay * t);
        m.rot_12 = round_sat(yz - xs);
        m.rot_20 = round_sat(xz - ys);
        m.rot_21 = round_sat(yz + xs);
        m.rot_22 = round_sat(cq + az * az * t);
        return m;
    endfunction

    // Send one beat, with an optional idle burst first
    task automatic send_beat(logic signed [15:0] ang, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        t_in b;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        b = '{angle: ang, axis_x: x, axis_y: y, axis_z: z};
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        matrix_q.push_back(rotation_matrix(b));
    endtask

    function automatic logic signed [15:0] unit_axis();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic test_corners();
        logic signed [15:0] angs[9] = '{0, 12868, -12868, 12869, -12869,
                                       25736, -25736, 32767, -32768};
        foreach (angs[k]) send_beat(angs[k], 16384, 0, 0);
        send_beat(8000, 0, 16384, 0);
        send_beat(-8000, 0, 0, 16384);
        send_beat(25736, -16384, 0, 0);
        send_beat(6434, 9459, 9459, 9459);
        // non-unit and out-of-range axes, some of which saturate
        send_beat(32767, 32767, 32767, 32767);
        send_beat(-32768, -32768, -32768, -32768);
        send_beat(12868, -32768, 32767, -32768);
        send_beat(0, 0, 0, 0);
        send_beat(-1, 32767, -32768, 1);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_beat(16'($urandom_range(0, 51472) - 25736),
                          unit_axis(), unit_axis(), unit_axis());
        end
    endtask

    task automatic test_streaming(int n);
        quiet = 1;
        test_random(n);
        i_in_valid <= 1'b0;
    endtask

    // Stall the output side in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_idle = 0;
            i_out_ready <= 1'b1;
        end else if (out_idle > 0) begin
            out_idle--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            out_idle = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (matrix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", o_out_data);
            end else begin
                t_out exp_m;
                exp_m = matrix_q.pop_front();
                if (exp_m !== o_out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("matrix mismatch: expected %h got %h", exp_m, o_out_data);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int guard;
        mismatches = 0;
        quiet      = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corners();
        test_random(900);
        test_streaming(200);
        guard = 0;
        while (matrix_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && matrix_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== axis_angle_rotation_matrix.f =====
+incdir+hdl
hdl/aarm_pkg.sv
hdl/aarm_cordic.sv
hdl/aarm_matrix.sv
hdl/axis_angle_rotation_matrix.sv
verif/axis_angle_rotation_matrix_test.sv
